// ----- sv/ttdtlp_pkg.sv -----
`timescale 1ns / 1ps

package ttdtlp_pkg;

  // Register indexes on the configuration channel
  localparam logic [7:0] REG_DEBOUNCE   = 8'd0;
  localparam logic [7:0] REG_TAP_MAX    = 8'd1;
  localparam logic [7:0] REG_DOUBLE_GAP = 8'd2;
  localparam logic [7:0] REG_LONG_TOUCH = 8'd3;

  localparam logic [15:0] DEBOUNCE_RST   = 16'd25;
  localparam logic [15:0] TAP_MAX_RST    = 16'd500;
  localparam logic [15:0] DOUBLE_GAP_RST = 16'd350;
  localparam logic [15:0] LONG_TOUCH_RST = 16'd1500;

  typedef enum logic [1:0] {
    GEST_TAP    = 2'd0,
    GEST_DOUBLE = 2'd1,
    GEST_LONG   = 2'd2
  } gesture_e;

  typedef struct packed {
    logic [15:0] settle_ms;
    logic [15:0] tap_limit_ms;
    logic [15:0] double_gap_ms;
    logic [15:0] hold_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic        stable_level;
    logic        candidate_level;
    logic [31:0] candidate_since;
    logic [31:0] press_time;
    logic        long_done;
    logic        tap_waiting;
    logic [31:0] release_time;
    logic        second_press;
  } tstate_t;

  typedef struct packed {
    gesture_e    gesture;
    logic [31:0] hold_ms;
    logic        last_of_poll;
  } result_t;

  // Results of one poll, in emission order
  typedef struct packed {
    logic [1:0] count;
    result_t    res1;
    result_t    res0;
  } poll_out_t;

endpackage

// ----- sv/ttdtlp_classify.sv -----
`timescale 1ns / 1ps

module ttdtlp_classify import ttdtlp_pkg::*; (
  input  tstate_t     state_i,
  input  cfg_t        cfg_i,
  input  logic        touch_level_i,
  input  logic [31:0] now_ms_i,
  output tstate_t     state_o,
  output poll_out_t   poll_o
);

  always_comb begin
    tstate_t     ns;
    logic [1:0]  cnt;
    result_t     r0;
    result_t     r1;
    logic [31:0] since_dt;
    logic [31:0] rel_dt;
    logic [31:0] dur;
    logic [31:0] held;
    logic [31:0] gap_dt;

    ns       = state_i;
    cnt      = 2'd0;
    r0       = '{gesture: GEST_TAP, hold_ms: 32'd0, last_of_poll: 1'b0};
    r1       = '{gesture: GEST_TAP, hold_ms: 32'd0, last_of_poll: 1'b0};
    since_dt = now_ms_i - state_i.candidate_since;
    rel_dt   = now_ms_i - state_i.release_time;
    dur      = now_ms_i - state_i.press_time;

    // Debounce, then press or release handling
    if (touch_level_i != state_i.candidate_level) begin
      ns.candidate_level = touch_level_i;
      ns.candidate_since = now_ms_i;
    end else if (state_i.candidate_level != state_i.stable_level &&
                 since_dt >= {16'd0, cfg_i.settle_ms}) begin
      ns.stable_level = state_i.candidate_level;
      if (state_i.candidate_level) begin
        ns.press_time   = now_ms_i;
        ns.long_done    = 1'b0;
        ns.second_press = state_i.tap_waiting &&
                          (rel_dt <= {16'd0, cfg_i.double_gap_ms});
      end else if (!state_i.long_done && dur <= {16'd0, cfg_i.tap_limit_ms}) begin
        if (state_i.second_press) begin
          ns.tap_waiting  = 1'b0;
          ns.second_press = 1'b0;
          r0.gesture      = GEST_DOUBLE;
          cnt             = 2'd1;
        end else begin
          ns.tap_waiting  = 1'b1;
          ns.release_time = now_ms_i;
        end
      end else if (!state_i.long_done) begin
        if (state_i.second_press && state_i.tap_waiting) begin
          ns.tap_waiting = 1'b0;
          r0.gesture     = GEST_TAP;
          cnt            = 2'd1;
        end
        ns.second_press = 1'b0;
      end
    end

    // Long touch check, flushing a pending first tap ahead of it
    held = now_ms_i - ns.press_time;
    if (ns.stable_level && !ns.long_done && held >= {16'd0, cfg_i.hold_limit_ms}) begin
      ns.long_done = 1'b1;
      if (ns.second_press && ns.tap_waiting) begin
        ns.tap_waiting  = 1'b0;
        ns.second_press = 1'b0;
        if (cnt == 2'd0) begin
          r0.gesture = GEST_TAP;
        end else begin
          r1.gesture = GEST_TAP;
        end
        cnt = cnt + 2'd1;
      end
      if (cnt == 2'd0) begin
        r0.gesture = GEST_LONG;
        r0.hold_ms = held;
      end else begin
        r1.gesture = GEST_LONG;
        r1.hold_ms = held;
      end
      cnt = cnt + 2'd1;
    end

    // Pending tap whose gap window has run out
    gap_dt = now_ms_i - ns.release_time;
    if (ns.tap_waiting && !ns.stable_level && gap_dt > {16'd0, cfg_i.double_gap_ms}) begin
      ns.tap_waiting = 1'b0;
      if (cnt == 2'd0) begin
        r0.gesture = GEST_TAP;
      end else begin
        r1.gesture = GEST_TAP;
      end
      cnt = cnt + 2'd1;
    end

    r0.last_of_poll = (cnt == 2'd1);
    r1.last_of_poll = (cnt == 2'd2);

    state_o      = ns;
    poll_o.count = cnt;
    poll_o.res0  = r0;
    poll_o.res1  = r1;
  end

endmodule

// ----- sv/ttdtlp_fifo.sv -----
`timescale 1ns / 1ps

module ttdtlp_fifo import ttdtlp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  poll_out_t push_i,
  input  logic      pop_i,
  output logic      space2_o,
  output logic      valid_o,
  output result_t   head_o
);

  result_t    mem_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic       do_pop;

  assign valid_o  = (count_q != 3'd0);
  assign head_o   = mem_q[rd_ptr_q];
  assign space2_o = (count_q <= 3'd2);
  assign do_pop   = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_i.count;
    rd_ptr_d = rd_ptr_q + {1'b0, do_pop};
    count_d  = count_q + {1'b0, push_i.count} - {2'd0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= push_i.res1;
    end
  end

endmodule

// ----- sv/touch_tap_double_tap_long_press.sv -----
`timescale 1ns / 1ps

// Touch gesture detector: debounce plus tap, double tap and long touch.
// Slave stream: one word per poll, tdata = {pad, now_ms, touch_level}.
// Master stream: one word per gesture; tuser carries the gesture code
// (tap, double tap, long touch), tdata the hold time of a long touch (else
// zero), tlast marks the final gesture of a poll. A poll emits 0 to 2 words.
// Configuration: cfg_valid_i/cfg_ready_o with a register index and 16-bit
// data (0 debounce, 1 tap max, 2 double gap, 3 long touch); other indexes
// are ignored. cfg_ready_o is always high.
// Latency: a gesture is visible on the master side the cycle after the poll
// is taken if the queue was empty. Throughput: one poll per cycle; the 4-entry
// result queue takes a poll whenever it has room for two words, so a stalled
// receiver holds s_axis_tready low once three or more words wait.
// Reset: thresholds return to their defaults, the queue empties, and the
// touch is taken as released with no tap pending.

module touch_tap_double_tap_long_press import ttdtlp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [0] touch_level, [32:1] now_ms, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] hold_ms
  output logic [1:0]  m_axis_tuser,   // [1:0] gesture
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t      cfg_q;
  tstate_t   state_q, state_d;
  poll_out_t poll;
  poll_out_t push;
  result_t   head;
  logic      in_fire;
  logic      space2;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = space2;
  assign in_fire       = s_axis_tvalid && space2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ms     <= DEBOUNCE_RST;
      cfg_q.tap_limit_ms  <= TAP_MAX_RST;
      cfg_q.double_gap_ms <= DOUBLE_GAP_RST;
      cfg_q.hold_limit_ms <= LONG_TOUCH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEBOUNCE:   cfg_q.settle_ms     <= cfg_data_i;
        REG_TAP_MAX:    cfg_q.tap_limit_ms  <= cfg_data_i;
        REG_DOUBLE_GAP: cfg_q.double_gap_ms <= cfg_data_i;
        REG_LONG_TOUCH: cfg_q.hold_limit_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ttdtlp_classify u_classify (
    .state_i       (state_q),
    .cfg_i         (cfg_q),
    .touch_level_i (s_axis_tdata[0]),
    .now_ms_i      (s_axis_tdata[32:1]),
    .state_o       (state_d),
    .poll_o        (poll)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Drop the poll's results unless the poll word is actually taken
  always_comb begin
    push = poll;
    if (!in_fire) begin
      push.count = 2'd0;
    end
  end

  ttdtlp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (m_axis_tready),
    .space2_o (space2),
    .valid_o  (m_axis_tvalid),
    .head_o   (head)
  );

  assign m_axis_tdata = head.hold_ms;
  assign m_axis_tuser = head.gesture;
  assign m_axis_tlast = head.last_of_poll;

endmodule

// ----- dv/touch_tap_double_tap_long_press_tb.sv -----
`timescale 1ns / 1ps

module touch_tap_double_tap_long_press_tb;
  import ttdtlp_pkg::*;

  localparam int POLL_TARGET = 1090;
  localparam logic [7:0] REG_UNUSED_LO = 8'd4;
  localparam logic [7:0] REG_UNUSED_HI = 8'hFF;
  localparam int SETTLE_CYCLES = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [0] touch_level, [32:1] now_ms, rest zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] hold_ms
  logic [1:0]  m_axis_tuser;   // [1:0] gesture
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  touch_tap_double_tap_long_press dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  class gesture_scoreboard;
    logic [15:0] settle_ms, tap_limit_ms, double_gap_ms, hold_limit_ms;
    bit          stable_lvl, cand_lvl, long_done, tap_waiting, second_press;
    logic [31:0] cand_since, press_at, release_at;
    result_t     pending_gestures[$];
    int          polls, taps, doubles, longs, pairs, mismatches;

    function new();
      settle_ms     = DEBOUNCE_RST;
      tap_limit_ms  = TAP_MAX_RST;
      double_gap_ms = DOUBLE_GAP_RST;
      hold_limit_ms = LONG_TOUCH_RST;
      stable_lvl    = 1'b0;
      cand_lvl      = 1'b0;
      long_done     = 1'b0;
      tap_waiting   = 1'b0;
      second_press  = 1'b0;
      cand_since    = '0;
      press_at      = '0;
      release_at    = '0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [15:0] val);
      case (idx)
        REG_DEBOUNCE:   settle_ms     = val;
        REG_TAP_MAX:    tap_limit_ms  = val;
        REG_DOUBLE_GAP: double_gap_ms = val;
        REG_LONG_TOUCH: hold_limit_ms = val;
        default: ;
      endcase
    endfunction

    function void emit(gesture_e g, logic [31:0] hold);
      result_t r;
      r.gesture      = g;
      r.hold_ms      = hold;
      r.last_of_poll = 1'b0;
      pending_gestures.push_back(r);
      case (g)
        GEST_TAP:    taps++;
        GEST_DOUBLE: doubles++;
        default:     longs++;
      endcase
    endfunction

    // Debounce, then release/press handling, long touch, and pending tap, in that order
    function void classify_poll(bit lvl, logic [31:0] now);
      logic [31:0] since_cand, dur, held, since_rel;
      result_t     tail;
      int          first;
      first = pending_gestures.size();
      polls++;
      since_cand = now - cand_since;
      if (lvl != cand_lvl) begin
        cand_lvl   = lvl;
        cand_since = now;
      end else if (cand_lvl != stable_lvl && since_cand >= {16'd0, settle_ms}) begin
        stable_lvl = cand_lvl;
        if (stable_lvl) begin
          since_rel    = now - release_at;
          press_at     = now;
          long_done    = 1'b0;
          second_press = tap_waiting && (since_rel <= {16'd0, double_gap_ms});
        end else begin
          dur = now - press_at;
          if (!long_done && dur <= {16'd0, tap_limit_ms}) begin
            if (second_press) begin
              tap_waiting  = 1'b0;
              second_press = 1'b0;
              emit(GEST_DOUBLE, '0);
            end else begin
              tap_waiting = 1'b1;
              release_at  = now;
            end
          end else if (!long_done) begin
            // a mid-length second press flushes the first tap
            if (second_press && tap_waiting) begin
              tap_waiting = 1'b0;
              emit(GEST_TAP, '0);
            end
            second_press = 1'b0;
          end
        end
      end
      held = now - press_at;
      if (stable_lvl && !long_done && held >= {16'd0, hold_limit_ms}) begin
        long_done = 1'b1;
        if (second_press && tap_waiting) begin
          tap_waiting  = 1'b0;
          second_press = 1'b0;
          emit(GEST_TAP, '0);
        end
        emit(GEST_LONG, held);
      end
      since_rel = now - release_at;
      if (tap_waiting && !stable_lvl && since_rel > {16'd0, double_gap_ms}) begin
        tap_waiting = 1'b0;
        emit(GEST_TAP, '0);
      end
      if (pending_gestures.size() > first) begin
        tail = pending_gestures.pop_back();
        tail.last_of_poll = 1'b1;
        pending_gestures.push_back(tail);
      end
      if (pending_gestures.size() - first == 2) pairs++;
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [1:0] g, logic [31:0] hold, logic last);
      result_t want;
      if (pending_gestures.size() == 0) begin
        report($sformatf("unexpected word gesture=%0d hold=%0d last=%0b", g, hold, last));
      end else begin
        want = pending_gestures.pop_front();
        if (g !== want.gesture)
          report($sformatf("gesture got %0d want %0d", g, want.gesture));
        if (hold !== want.hold_ms)
          report($sformatf("hold_ms got %0d want %0d", hold, want.hold_ms));
        if (last !== want.last_of_poll)
          report($sformatf("tlast got %0b want %0b", last, want.last_of_poll));
      end
    endtask

    function bit busy();
      return pending_gestures.size() != 0;
    endfunction
  endclass

  gesture_scoreboard sb = new();
  logic [31:0] stamp;
  int          src_gap_max = 16;
  int          snk_gap_max = 16;
  int          settings_used;

  task automatic cfg_write(logic [7:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_poll(bit lvl, logic [31:0] at);
    int gap;
    gap = $urandom_range(src_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, at, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.classify_poll(lvl, at);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.busy()) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Hold one level for span ms over a few polls, then step past it
  task automatic dwell(bit lvl, int unsigned span);
    int unsigned n, step;
    n    = $urandom_range(4, 1);
    step = span / n;
    send_poll(lvl, stamp);
    for (int i = 1; i <= n; i++) begin
      stamp += (i == n) ? span - step * (n - 1) : step;
      send_poll(lvl, stamp);
    end
    stamp += $urandom_range(step + 1, 1);
  endtask

  // Bounce the raw level in steps no longer than the debounce window
  task automatic chatter();
    int n;
    n = $urandom_range(4, 1);
    repeat (n) begin
      send_poll(1'($urandom_range(1)), stamp);
      stamp += $urandom_range(sb.settle_ms);
    end
  endtask

  function automatic int unsigned around(int unsigned lim);
    int unsigned v;
    case ($urandom_range(2))
      0: begin
        v = lim + $urandom_range(4);
        v = (v >= 2) ? v - 2 : 0;
      end
      1: v = $urandom_range(lim);
      default: v = lim + $urandom_range(lim / 2 + 8, 1);
    endcase
    return v;
  endfunction

  // 0 short, 1 near the tap limit, 2 between tap and long, 3 long
  function automatic int unsigned press_span(int k);
    int unsigned db, tp, lt;
    db = {16'd0, sb.settle_ms};
    tp = {16'd0, sb.tap_limit_ms};
    lt = {16'd0, sb.hold_limit_ms};
    case (k)
      0: return db + $urandom_range(tp);
      1: return db + around(tp);
      2: return db + ((tp < lt) ? $urandom_range(lt, tp) : $urandom_range(tp, lt));
      default: return db + lt + $urandom_range(lt / 4 + 5);
    endcase
  endfunction

  // 0 inside the double gap, 1 near it, 2 past it
  function automatic int unsigned gap_span(int k);
    int unsigned db, gp;
    db = {16'd0, sb.settle_ms};
    gp = {16'd0, sb.double_gap_ms};
    case (k)
      0: return db + $urandom_range(gp);
      1: return db + around(gp);
      default: return db + gp + $urandom_range(gp + 20, 1);
    endcase
  endfunction

  function automatic int pick_gap_max();
    case ($urandom_range(2))
      0: return 0;
      1: return 4;
      default: return 16;
    endcase
  endfunction

  task automatic gesture_sequence();
    int n;
    case ($urandom_range(9))
      0, 1: begin
        dwell(1'b1, press_span($urandom_range(3)));
        dwell(1'b0, gap_span($urandom_range(2)));
      end
      2, 3: begin
        dwell(1'b1, press_span($urandom_range(1)));
        dwell(1'b0, gap_span($urandom_range(1)));
        dwell(1'b1, press_span($urandom_range(3)));
        dwell(1'b0, gap_span($urandom_range(2)));
      end
      4: begin
        dwell(1'b1, press_span(0));
        dwell(1'b0, gap_span(0));
        dwell(1'b1, press_span(3));
        dwell(1'b0, gap_span(2));
      end
      5: chatter();
      6: begin
        stamp += $urandom;
        dwell(1'($urandom_range(1)), press_span($urandom_range(3)));
      end
      7: begin
        stamp -= $urandom_range(2000, 1);
        dwell(1'($urandom_range(1)), press_span($urandom_range(3)));
      end
      8: begin
        n = $urandom_range(8, 3);
        repeat (n) begin
          send_poll(1'($urandom_range(1)), stamp);
          stamp += $urandom_range(2 * sb.hold_limit_ms + 10);
        end
      end
      default: begin
        dwell(1'b1, press_span(0));
        chatter();
        dwell(1'b0, gap_span(2));
      end
    endcase
  endtask

  task automatic load_thresholds(logic [15:0] db, logic [15:0] tp, logic [15:0] gp,
                                 logic [15:0] lt);
    cfg_write(REG_DEBOUNCE, db);
    cfg_write(REG_TAP_MAX, tp);
    cfg_write(REG_DOUBLE_GAP, gp);
    cfg_write(REG_LONG_TOUCH, lt);
    settings_used++;
  endtask

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      int gap;
      gap = $urandom_range(snk_gap_max);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        // start the stall once a word is offered
        do @(posedge clk_i); while (!m_axis_tvalid);
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      @(negedge clk_i);
    end
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero debounce, tight windows, wrap across zero
    load_thresholds(16'd0, 16'd10, 16'd10, 16'd40);
    cfg_write(REG_UNUSED_LO, 16'hFFFF);
    cfg_write(REG_UNUSED_HI, 16'h0000);
    send_poll(1'b1, 32'hFFFF_FFFE);
    send_poll(1'b1, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'd3);
    send_poll(1'b0, 32'd4);       // first short tap waits
    send_poll(1'b1, 32'd6);
    send_poll(1'b1, 32'd7);
    send_poll(1'b0, 32'd9);
    send_poll(1'b0, 32'd10);      // double tap
    send_poll(1'b1, 32'd11);
    send_poll(1'b1, 32'd12);
    send_poll(1'b0, 32'd14);
    send_poll(1'b0, 32'd15);
    send_poll(1'b1, 32'd16);
    send_poll(1'b1, 32'd17);
    send_poll(1'b1, 32'd57);      // tap flushed, then long touch
    send_poll(1'b0, 32'd58);
    send_poll(1'b0, 32'd59);
    send_poll(1'b1, 32'd60);
    send_poll(1'b1, 32'd61);
    send_poll(1'b0, 32'd63);
    send_poll(1'b0, 32'd64);
    send_poll(1'b0, 32'd75);      // gap window expired: tap
    send_poll(1'b1, 32'd0);       // timestamp goes backward
    send_poll(1'b0, 32'd0);
    wait_idle();

    stamp = 32'hFFFF_F000 + $urandom_range(4095);
    while (sb.polls < POLL_TARGET) begin
      case (settings_used)
        1: load_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
        2: load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: begin
          if ($urandom_range(3) == 0)
            load_thresholds(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom));
          else
            load_thresholds(16'($urandom_range(12)), 16'($urandom_range(80, 5)),
                            16'($urandom_range(80, 5)), 16'($urandom_range(250, 60)));
        end
      endcase
      if ($urandom_range(1))
        cfg_write(8'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)), 16'($urandom));
      src_gap_max = pick_gap_max();
      snk_gap_max = pick_gap_max();
      repeat ($urandom_range(14, 6)) gesture_sequence();
      // hold the sender until every gesture of this setting is out
      wait_idle();
    end

    $display("Ran %0d polls across %0d threshold settings, wrapping and backward timestamps",
             sb.polls, settings_used);
    $display("Saw %0d taps, %0d double taps, %0d long touches, %0d two-gesture polls",
             sb.taps, sb.doubles, sb.longs, sb.pairs);
    if (sb.mismatches == 0) begin
      $display("touch_tap_double_tap_long_press test passed");
    end else begin
      $display("touch_tap_double_tap_long_press test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d gestures outstanding", sb.pending_gestures.size());
    $display("touch_tap_double_tap_long_press test failed");
    $finish;
  end

endmodule
